// ----- hdl/pinlk_pkg.sv -----
// Shared types and constants of the PIN entry lock.
package pinlk_pkg;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 24;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_PIN  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FAILURES  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_DURATION = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_REPORT   = 4'd3;

  localparam logic [23:0] EXPECTED_PIN_RST  = 24'h123456;
  localparam logic [3:0]  MAX_FAILURES_RST  = 4'd3;
  localparam logic [15:0] LOCK_DURATION_RST = 16'd3000;
  localparam logic [7:0]  LOCK_REPORT_RST   = 8'd30;

  // Event codes
  localparam logic [2:0] MODE_INC   = 3'd0;
  localparam logic [2:0] MODE_CONF  = 3'd1;
  localparam logic [2:0] MODE_BACK  = 3'd2;
  localparam logic [2:0] MODE_T10MS = 3'd3;
  localparam logic [2:0] MODE_T1S   = 3'd4;
  localparam logic [2:0] MODE_HOST  = 3'd5;

  // Frame kinds
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_KEY   = 3'd1;
  localparam logic [2:0] KIND_OK    = 3'd2;
  localparam logic [2:0] KIND_ERR   = 3'd3;
  localparam logic [2:0] KIND_LOCK  = 3'd4;
  localparam logic [2:0] KIND_READY = 3'd5;
  localparam logic [2:0] KIND_BACK  = 3'd6;
  localparam logic [2:0] KIND_ALIVE = 3'd7;

  localparam logic [7:0] LED_OK    = 8'hFF;
  localparam logic [7:0] LED_ERR   = 8'h00;
  localparam logic [7:0] LED_LOCK  = 8'h81;
  localparam logic [7:0] LED_READY = 8'h18;

  localparam logic [31:0] HELLO_WORD = 32'h534B484C;
  localparam logic [3:0]  FAIL_SAT   = 4'd15;
  localparam logic [3:0]  DIGIT_MAX  = 4'd9;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] arg;
    logic       confirm;
    logic       led_valid;
    logic [7:0] led_pattern;
  } frame_t;

  // All frames caused by one event; count is 1 to 3 for a queued bundle
  typedef struct packed {
    frame_t [2:0] frm;
    logic   [1:0] count;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- hdl/pinlk_front.sv -----
// Front end: configuration registers, lock state and event classification.
module pinlk_front import pinlk_pkg::*; #(
  parameter int PIN_DIGITS = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  input  logic [2:0]            mode,
  input  logic [31:0]           rx_word,
  output logic                  push,
  output bundle_t               bundle
);

  localparam int PW = $clog2(PIN_DIGITS + 1);
  localparam logic [PW-1:0] POS_FULL = PW'(PIN_DIGITS);

  logic [23:0] expected_pin;
  logic [3:0]  max_failures;
  logic [15:0] lock_duration;
  logic [7:0]  lock_report;

  logic [3:0]    digits      [PIN_DIGITS];
  logic [3:0]    digits_next [PIN_DIGITS];
  logic [3:0]    digits_w    [PIN_DIGITS];
  logic [PW-1:0] pos, pos_next, pos_inc, pos_dec;
  logic [3:0]    dig, dig_next;
  logic [3:0]    fail_cnt, fail_cnt_next, fail_inc;
  logic          locked, locked_next;
  logic [15:0]   countdown, countdown_next;
  logic          online, online_next;
  logic [31:0]   pin_ext;
  logic          match;
  bundle_t       bun;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_pin  <= EXPECTED_PIN_RST;
      max_failures  <= MAX_FAILURES_RST;
      lock_duration <= LOCK_DURATION_RST;
      lock_report   <= LOCK_REPORT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXPECTED_PIN:  expected_pin  <= cfg_data;
        CFG_MAX_FAILURES:  max_failures  <= cfg_data[3:0];
        CFG_LOCK_DURATION: lock_duration <= cfg_data[15:0];
        CFG_LOCK_REPORT:   lock_report   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign pin_ext  = {8'h00, expected_pin};
  assign pos_inc  = pos + PW'(1);
  assign pos_dec  = pos - PW'(1);
  assign fail_inc = (fail_cnt == FAIL_SAT) ? FAIL_SAT : fail_cnt + 4'd1;

  // Entry as it stands once the confirm key has stored the edited digit
  always_comb begin
    for (int i = 0; i < PIN_DIGITS; i++) begin
      digits_w[i] = (pos == PW'(i)) ? dig : digits[i];
    end
  end

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < PIN_DIGITS; i++) begin
      if (digits_w[i] != pin_ext[4*(PIN_DIGITS-1-i) +: 4]) match = 1'b0;
    end
  end

  always_comb begin
    digits_next    = digits;
    pos_next       = pos;
    dig_next       = dig;
    fail_cnt_next  = fail_cnt;
    locked_next    = locked;
    countdown_next = countdown;
    online_next    = online;
    bun            = '0;
    case (mode)
      MODE_INC: begin
        if (!locked) begin
          online_next = 1'b1;
          dig_next = (dig >= DIGIT_MAX) ? 4'd0 : dig + 4'd1;
          bun.frm[0].kind = KIND_KEY;
          bun.frm[0].arg  = 8'(pos);
          bun.count = 2'd1;
        end
      end
      MODE_CONF: begin
        // a confirm on a completed entry does nothing
        if (!locked) begin
          online_next = 1'b1;
          if (pos < POS_FULL) begin
            digits_next = digits_w;
            pos_next = pos_inc;
            dig_next = 4'd0;
            bun.frm[0].kind    = KIND_KEY;
            bun.frm[0].arg     = 8'(pos_inc);
            bun.frm[0].confirm = 1'b1;
            bun.count = 2'd1;
            if (pos_inc == POS_FULL) begin
              bun.frm[1].led_valid = 1'b1;
              bun.count = 2'd2;
              if (match) begin
                fail_cnt_next = 4'd0;
                bun.frm[1].kind        = KIND_OK;
                bun.frm[1].led_pattern = LED_OK;
              end else begin
                fail_cnt_next = fail_inc;
                bun.frm[1].kind        = KIND_ERR;
                bun.frm[1].arg         = 8'(fail_inc);
                bun.frm[1].led_pattern = LED_ERR;
                if (fail_inc >= max_failures) begin
                  locked_next    = 1'b1;
                  countdown_next = lock_duration;
                  bun.frm[2].kind        = KIND_LOCK;
                  bun.frm[2].arg         = lock_report;
                  bun.frm[2].led_valid   = 1'b1;
                  bun.frm[2].led_pattern = LED_LOCK;
                  bun.count = 2'd3;
                end
                for (int i = 0; i < PIN_DIGITS; i++) digits_next[i] = 4'd0;
                pos_next = '0;
                dig_next = 4'd0;
              end
            end
          end
        end
      end
      MODE_BACK: begin
        if (!locked) begin
          online_next = 1'b1;
          dig_next = 4'd0;
          if (pos != '0) begin
            pos_next = pos_dec;
            // pull the previous digit back into edit
            for (int i = 0; i < PIN_DIGITS; i++) begin
              if (pos_dec == PW'(i)) begin
                dig_next = digits[i];
                digits_next[i] = 4'd0;
              end
            end
          end
          bun.frm[0].kind = KIND_BACK;
          bun.frm[0].arg  = 8'(pos_next);
          bun.count = 2'd1;
        end
      end
      MODE_T10MS: begin
        if (locked && countdown != 16'd0) begin
          countdown_next = countdown - 16'd1;
          if (countdown == 16'd1) begin
            locked_next   = 1'b0;
            fail_cnt_next = 4'd0;
            for (int i = 0; i < PIN_DIGITS; i++) digits_next[i] = 4'd0;
            pos_next = '0;
            dig_next = 4'd0;
            bun.frm[0].kind        = KIND_NONE;
            bun.frm[0].led_valid   = 1'b1;
            bun.frm[0].led_pattern = LED_READY;
            bun.count = 2'd1;
          end
        end
      end
      MODE_T1S: begin
        if (online) begin
          bun.frm[0].kind = KIND_ALIVE;
          bun.count = 2'd1;
        end
      end
      MODE_HOST: begin
        if (rx_word == HELLO_WORD) begin
          online_next   = 1'b1;
          locked_next   = 1'b0;
          fail_cnt_next = 4'd0;
          for (int i = 0; i < PIN_DIGITS; i++) digits_next[i] = 4'd0;
          pos_next = '0;
          dig_next = 4'd0;
          bun.frm[0].kind        = KIND_READY;
          bun.frm[0].led_valid   = 1'b1;
          bun.frm[0].led_pattern = LED_READY;
          bun.count = 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIN_DIGITS; i++) digits[i] <= 4'd0;
      pos       <= '0;
      dig       <= 4'd0;
      fail_cnt  <= 4'd0;
      locked    <= 1'b0;
      countdown <= 16'd0;
      online    <= 1'b1;
    end else if (accept) begin
      digits    <= digits_next;
      pos       <= pos_next;
      dig       <= dig_next;
      fail_cnt  <= fail_cnt_next;
      locked    <= locked_next;
      countdown <= countdown_next;
      online    <= online_next;
    end
  end

  assign push   = accept && (bun.count != 2'd0);
  assign bundle = bun;

endmodule

// ----- hdl/pinlk_queue.sv -----
// Short queue of result bundles between the front and back ends.
module pinlk_queue import pinlk_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output bundle_t head,
  output q_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  bundle_t       mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [CW-1:0] fill;

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= (wptr == LAST_SLOT) ? '0 : wptr + AW'(1);
      if (pop)  rptr <= (rptr == LAST_SLOT) ? '0 : rptr + AW'(1);
      case ({push, pop})
        2'b10:   fill <= fill + CW'(1);
        2'b01:   fill <= fill - CW'(1);
        default: ;
      endcase
    end
  end

  assign head       = mem[rptr];
  assign stat.full  = (fill == CW'(DEPTH));
  assign stat.empty = (fill == '0);

endmodule

// ----- hdl/pinlk_back.sv -----
// Back end: walks the frames of the head bundle out one per transaction.
module pinlk_back import pinlk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  bundle_t    head,
  input  q_stat_t    stat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] frame_kind,
  output logic [7:0] frame_arg,
  output logic       confirm_flag,
  output logic       led_valid,
  output logic [7:0] led_pattern,
  output logic       last
);

  logic [1:0] idx;
  frame_t     cur;
  logic       take;

  assign cur       = head.frm[idx];
  assign out_valid = !stat.empty;
  assign last      = (idx == head.count - 2'd1);
  assign take      = out_valid && !out_stall;
  assign pop       = take && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (take) begin
      // drop the bundle after its final frame, else advance
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

  assign frame_kind   = cur.kind;
  assign frame_arg    = cur.arg;
  assign confirm_flag = cur.confirm;
  assign led_valid    = cur.led_valid;
  assign led_pattern  = cur.led_pattern;

endmodule

// ----- hdl/pin_entry_lock_with_lockout.sv -----
// Top level of the PIN entry lock with failure lockout.
// Each event (key, tick or host frame) is taken on its own: the front end updates the lock
// state at once and queues the frames that the event causes, so a new event can be accepted
// every cycle while the queue (QUEUE_DEPTH bundles) has room. The back end sends one result
// transaction per cycle from the queue head while out_stall is low, so an event yields as many
// output transactions as it has frames: one for most events, two or three for the confirm that
// completes an entry; events with no frames queue nothing. Configuration writes are always ready
// and must be made while no results are pending.
module pin_entry_lock_with_lockout import pinlk_pkg::*; #(
  parameter int PIN_DIGITS  = 6,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            mode,
  input  logic [31:0]           rx_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            frame_kind,
  output logic [7:0]            frame_arg,
  output logic                  confirm_flag,
  output logic                  led_valid,
  output logic [7:0]            led_pattern,
  output logic                  last
);

  logic    accept, push, pop;
  bundle_t bundle, head;
  q_stat_t stat;

  assign cfg_ready = 1'b1;
  assign in_stall  = stat.full;
  assign accept    = in_valid && !in_stall;

  pinlk_front #(.PIN_DIGITS(PIN_DIGITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .mode      (mode),
    .rx_word   (rx_word),
    .push      (push),
    .bundle    (bundle)
  );

  pinlk_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (bundle),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  pinlk_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .stat         (stat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_kind   (frame_kind),
    .frame_arg    (frame_arg),
    .confirm_flag (confirm_flag),
    .led_valid    (led_valid),
    .led_pattern  (led_pattern),
    .last         (last)
  );

  // A frame that is not the last of its event is always followed by another
  a_bundle_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid)
    else $error("result bundle ended without a last frame");

  // The input side only stalls while results are waiting
  a_stall_needs_backlog: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no pending results");

  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(stat.full && stat.empty))
    else $error("queue reports full and empty at once");

endmodule
